// File: rtl/core/hierarchical_timer_wheel_defines.svh
// ---------------------------------------------------------------------------
// Timer wheel assertion macros
// Concurrent property shorthands for the port checker.
// ---------------------------------------------------------------------------
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer wheel check failed");

// next-cycle implication, sampled on clk, off during rst
`define HTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer wheel check failed");

`endif

// File: rtl/core/htw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer wheel package
// Command and result codes, fixed field widths and a shared shift helper.
// ---------------------------------------------------------------------------
package htw_pkg;

  // input command codes (s_tuser)
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds (m_tuser)
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  // fixed field widths
  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 31;
  localparam int HANDLE_W = 16;

  // results reported per tick
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  // logical right shift where 32 or more clears the word
  function automatic logic [TIME_W-1:0] shr32(input logic [TIME_W-1:0] v, input int sh);
    if (sh >= TIME_W) return '0;
    return v >> sh;
  endfunction

endpackage

// File: rtl/core/htw_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer wheel RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/htw_file.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer wheel slot select
// Picks the wheel slot for an expiry time from its distance to now.
// ---------------------------------------------------------------------------
module htw_file
  import htw_pkg::*;
#(
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int SLOT_W     = 9
) (
  input  logic [TIME_W-1:0] expiry,
  input  logic [TIME_W-1:0] now,
  output logic [SLOT_W-1:0] slot
);

  localparam int ROOT_SLOTS  = 1 << ROOT_BITS;
  localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
  localparam logic [SLOT_W-1:0] BASE1 = SLOT_W'(ROOT_SLOTS);
  localparam logic [SLOT_W-1:0] BASE2 = SLOT_W'(ROOT_SLOTS + LEVEL_SLOTS);
  localparam logic [SLOT_W-1:0] BASE3 = SLOT_W'(ROOT_SLOTS + 2 * LEVEL_SLOTS);
  localparam logic [SLOT_W-1:0] BASE4 = SLOT_W'(ROOT_SLOTS + 3 * LEVEL_SLOTS);

  // distance below 2^sh
  function automatic logic fits(input logic [TIME_W-1:0] d, input int sh);
    if (sh >= TIME_W) return 1'b1;
    return (d >> sh) == '0;
  endfunction

  logic [TIME_W-1:0] distance;
  logic [TIME_W-1:0] w1, w2, w3, w4;

  assign distance = expiry - now;
  assign w1   = shr32(expiry, ROOT_BITS);
  assign w2   = shr32(expiry, ROOT_BITS + LEVEL_BITS);
  assign w3   = shr32(expiry, ROOT_BITS + 2 * LEVEL_BITS);
  assign w4   = shr32(expiry, ROOT_BITS + 3 * LEVEL_BITS);

  // nearest level that covers the distance; past times go to the current slot
  always_comb begin
    if (fits(distance, ROOT_BITS)) begin
      slot = SLOT_W'(expiry[ROOT_BITS-1:0]);
    end else if (fits(distance, ROOT_BITS + LEVEL_BITS)) begin
      slot = BASE1 + SLOT_W'(w1[LEVEL_BITS-1:0]);
    end else if (fits(distance, ROOT_BITS + 2 * LEVEL_BITS)) begin
      slot = BASE2 + SLOT_W'(w2[LEVEL_BITS-1:0]);
    end else if (fits(distance, ROOT_BITS + 3 * LEVEL_BITS)) begin
      slot = BASE3 + SLOT_W'(w3[LEVEL_BITS-1:0]);
    end else if (distance[TIME_W-1]) begin
      slot = SLOT_W'(now[ROOT_BITS-1:0]);
    end else begin
      slot = BASE4 + SLOT_W'(w4[LEVEL_BITS-1:0]);
    end
  end

endmodule

// File: rtl/core/hierarchical_timer_wheel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hierarchical timer wheel
// Five-level timing wheel over a fixed timer pool, kept in three RAMs.
// ---------------------------------------------------------------------------
// Adds and ticks are taken one at a time; s_tready is high only between
// items. A reject waits for the output to be free. A tick walks the
// current root slot, freeing or re-arming each timer in it; at a root wrap
// each cascaded level re-files its timers first. Every walk follows the
// linked lists of the slot RAM and link RAM one timer at a time through
// their registered read ports. After reset a clearing pass empties all
// slots and chains the free list before the first item is taken.
module hierarchical_timer_wheel
  import htw_pkg::*;
#(
  parameter int NUM_TIMERS  = 64,
  parameter int ROOT_BITS   = 8,
  parameter int LEVEL_BITS  = 6,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // timer_handle[15:0], due_time[46:16], period[77:47]
  input  logic [0:0]  s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // handle_out[15:0]
  output logic [0:0]  m_tuser,   // result_kind[0]
  output logic        m_tlast
);

  localparam int ROOT_SLOTS  = 1 << ROOT_BITS;
  localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
  localparam int TOTAL_SLOTS = ROOT_SLOTS + 4 * LEVEL_SLOTS;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
  localparam int PTR_W       = $clog2(NUM_TIMERS + 1);
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TAG_W       = HANDLE_BITS;
  localparam int DATA_W      = TIME_W + DELAY_W + TAG_W;
  localparam int CLR_LEN     = (TOTAL_SLOTS > NUM_TIMERS) ? TOTAL_SLOTS : NUM_TIMERS;
  localparam int CLR_W       = $clog2(CLR_LEN);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_TIMERS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ADD    = 13'b0000000000100,
    S_ADD2   = 13'b0000000001000,
    S_AP1    = 13'b0000000010000,
    S_REJ    = 13'b0000000100000,
    S_CS0    = 13'b0000001000000,
    S_CS1    = 13'b0000010000000,
    S_RT0    = 13'b0000100000000,
    S_RT1    = 13'b0001000000000,
    S_WALK   = 13'b0010000000000,
    S_VISIT  = 13'b0100000000000,
    S_REFILE = 13'b1000000000000
  } state_t;

  state_t state;

  logic [CLR_W-1:0]    clr_cnt;
  logic [TIME_W-1:0]   wheel_time;
  logic [PTR_W-1:0]    free_head;
  logic [HANDLE_W-1:0] handle_r;
  logic [DELAY_W-1:0]  due_r;
  logic [DELAY_W-1:0]  per_r;
  logic [PTR_W-1:0]    t_cur;
  logic [PTR_W-1:0]    t_nxt;
  logic [SLOT_W-1:0]   slot_r;
  logic [1:0]          lvl;
  logic                cidx_zero;
  logic                drain;
  logic                ret_walk;
  logic [TIME_W-1:0]   exp_r;
  logic [CNT_W-1:0]    res_cnt;

  // RAM ports
  logic                  slot_we, slot_re;
  logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
  logic [2*PTR_W-1:0]    slot_wdata, slot_rd;
  logic                  link_we, link_re;
  logic [IDX_W-1:0]      link_waddr, link_raddr;
  logic [PTR_W-1:0]      link_wdata, link_rd;
  logic                  data_we, data_re;
  logic [IDX_W-1:0]      data_waddr, data_raddr;
  logic [DATA_W-1:0]     data_wdata, data_rd;

  logic [PTR_W-1:0]      rd_head, rd_tail;
  logic [TIME_W-1:0]     rd_exp;
  logic [DELAY_W-1:0]    rd_per;
  logic [TAG_W-1:0]      rd_tag;
  logic [TIME_W-1:0]     file_exp;
  logic [SLOT_W-1:0]     file_slot;
  logic [TIME_W-1:0]     cs_word;
  logic [LEVEL_BITS-1:0] cs_idx;
  logic [SLOT_W-1:0]     cs_slot;
  logic [SLOT_W-1:0]     root_slot;
  logic                  emit_ok;
  logic                  go;
  logic                  out_load;

  assign rd_head   = slot_rd[2*PTR_W-1:PTR_W];
  assign rd_tail   = slot_rd[PTR_W-1:0];
  assign rd_exp    = data_rd[DATA_W-1 -: TIME_W];
  assign rd_per    = data_rd[TAG_W +: DELAY_W];
  assign rd_tag    = data_rd[TAG_W-1:0];
  assign root_slot = SLOT_W'(wheel_time[ROOT_BITS-1:0]);
  assign emit_ok   = !m_tvalid || m_tready;
  assign go        = (res_cnt == CNT_MAX) || emit_ok;
  assign s_tready  = (state == S_IDLE);

  // a new result word is loaded this cycle
  assign out_load = ((state == S_REJ) && emit_ok) ||
                    ((state == S_VISIT) && drain && go && (res_cnt != CNT_MAX));

  // slot of the level being cascaded
  assign cs_word = shr32(wheel_time, ROOT_BITS + int'(lvl) * LEVEL_BITS);
  assign cs_idx  = cs_word[LEVEL_BITS-1:0];
  assign cs_slot = SLOT_W'(ROOT_SLOTS) + SLOT_W'({lvl, cs_idx});

  // expiry to file: fresh one for adds and re-arms, stored one for cascades
  assign file_exp = (state == S_VISIT) ? rd_exp : exp_r;

  htw_file #(
    .ROOT_BITS (ROOT_BITS),
    .LEVEL_BITS(LEVEL_BITS),
    .SLOT_W    (SLOT_W)
  ) u_file (
    .expiry(file_exp),
    .now   (wheel_time),
    .slot  (file_slot)
  );

  htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(TOTAL_SLOTS), .ADDR_W(SLOT_W)) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rd)
  );

  htw_ram #(.WIDTH(PTR_W), .DEPTH(NUM_TIMERS), .ADDR_W(IDX_W)) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (link_re),
    .raddr(link_raddr),
    .rdata(link_rd)
  );

  htw_ram #(.WIDTH(DATA_W), .DEPTH(NUM_TIMERS), .ADDR_W(IDX_W)) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .re   (data_re),
    .raddr(data_raddr),
    .rdata(data_rd)
  );

  // RAM accesses per state
  always_comb begin
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = slot_r;
    slot_raddr = file_slot;
    slot_wdata = {NIL, NIL};
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_waddr = IDX_W'(t_cur);
    link_raddr = IDX_W'(t_cur);
    link_wdata = NIL;
    data_we    = 1'b0;
    data_re    = 1'b0;
    data_waddr = IDX_W'(t_cur);
    data_raddr = IDX_W'(t_cur);
    data_wdata = {exp_r, rd_per, rd_tag};
    unique case (state)
      S_CLEAR: begin
        slot_we    = 32'(clr_cnt) < TOTAL_SLOTS;
        slot_waddr = SLOT_W'(clr_cnt);
        link_we    = 32'(clr_cnt) < NUM_TIMERS;
        link_waddr = IDX_W'(clr_cnt);
        link_wdata = PTR_W'(clr_cnt) + PTR_W'(1);
      end
      S_ADD: begin
        link_re    = (free_head != NIL);
        link_raddr = IDX_W'(free_head);
      end
      S_ADD2: begin
        data_we    = 1'b1;
        data_wdata = {exp_r, per_r, TAG_W'(handle_r)};
        link_we    = 1'b1;
        slot_re    = 1'b1;
      end
      S_AP1: begin
        slot_we    = 1'b1;
        slot_wdata = (rd_head == NIL) ? {t_cur, t_cur} : {rd_head, t_cur};
        link_we    = (rd_head != NIL);
        link_waddr = IDX_W'(rd_tail);
        link_wdata = t_cur;
      end
      S_CS0: begin
        slot_re    = 1'b1;
        slot_raddr = cs_slot;
      end
      S_RT0: begin
        slot_re    = 1'b1;
        slot_raddr = root_slot;
      end
      S_CS1, S_RT1: begin
        slot_we = 1'b1;
      end
      S_WALK: begin
        link_re = (t_cur != NIL);
        data_re = (t_cur != NIL);
      end
      S_VISIT: begin
        if (!drain) begin
          link_we = 1'b1;
          slot_re = 1'b1;
        end else if (go && rd_per == '0) begin
          link_we    = 1'b1;
          link_wdata = free_head;
        end
      end
      S_REFILE: begin
        data_we = 1'b1;
        link_we = 1'b1;
        slot_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      wheel_time <= '0;
      free_head  <= '0;
      m_tvalid   <= 1'b0;
      res_cnt    <= '0;
      lvl        <= '0;
      drain      <= 1'b0;
      ret_walk   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (32'(clr_cnt) == CLR_LEN - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            handle_r <= s_tdata[15:0];
            due_r    <= s_tdata[46:16];
            per_r    <= s_tdata[77:47];
            if (s_tuser[0] == CMD_ADD) begin
              state <= S_ADD;
            end else begin
              res_cnt <= '0;
              lvl     <= '0;
              if (wheel_time[ROOT_BITS-1:0] == '0) begin
                drain <= 1'b0;
                state <= S_CS0;
              end else begin
                drain <= 1'b1;
                state <= S_RT0;
              end
            end
          end
        end
        S_ADD: begin
          if (free_head == NIL) begin
            state <= S_REJ;
          end else begin
            t_cur    <= free_head;
            exp_r    <= wheel_time + TIME_W'(due_r);
            ret_walk <= 1'b0;
            state    <= S_ADD2;
          end
        end
        S_ADD2: begin
          free_head <= link_rd;
          slot_r    <= file_slot;
          state     <= S_AP1;
        end
        S_AP1: begin
          if (ret_walk) begin
            t_cur <= t_nxt;
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_REJ: begin
          if (emit_ok) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_REJECT;
            m_tdata  <= HANDLE_W'(TAG_W'(handle_r));
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_CS0: begin
          slot_r    <= cs_slot;
          cidx_zero <= (cs_idx == '0);
          state     <= S_CS1;
        end
        S_RT0: begin
          slot_r <= root_slot;
          state  <= S_RT1;
        end
        S_CS1, S_RT1: begin
          t_cur <= rd_head;
          state <= S_WALK;
        end
        S_WALK: begin
          if (t_cur != NIL) begin
            state <= S_VISIT;
          end else if (drain) begin
            wheel_time <= wheel_time + TIME_W'(1);
            state      <= S_IDLE;
          end else if (cidx_zero && lvl != 2'd3) begin
            lvl   <= lvl + 2'd1;
            state <= S_CS0;
          end else begin
            drain <= 1'b1;
            state <= S_RT0;
          end
        end
        S_VISIT: begin
          t_nxt <= link_rd;
          if (!drain) begin
            slot_r   <= file_slot;
            ret_walk <= 1'b1;
            state    <= S_AP1;
          end else if (go) begin
            // report while under the cap
            if (res_cnt != CNT_MAX) begin
              m_tvalid <= 1'b1;
              m_tuser  <= KIND_EXPIRED;
              m_tdata  <= HANDLE_W'(rd_tag);
              m_tlast  <= (link_rd == NIL) || (res_cnt == CNT_MAX - CNT_W'(1));
              res_cnt  <= res_cnt + CNT_W'(1);
            end
            if (rd_per != '0) begin
              exp_r <= wheel_time + TIME_W'(rd_per);
              state <= S_REFILE;
            end else begin
              free_head <= t_cur;
              t_cur     <= link_rd;
              state     <= S_WALK;
            end
          end
        end
        S_REFILE: begin
          slot_r   <= file_slot;
          ret_walk <= 1'b1;
          state    <= S_AP1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/htw_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer wheel port checker
// Port-level properties of the timer wheel, bound to the top level.
// ---------------------------------------------------------------------------
`include "hierarchical_timer_wheel_defines.svh"

module htw_checker
  import htw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tlast
);

  // a stalled result word holds
  `HTW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // a reject is always the only word of its item
  `HTW_ASSERT_NOW(a_reject_last, m_tvalid && m_tuser[0] == KIND_REJECT, m_tlast)

  // items are taken one at a time
  `HTW_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

  // no result appears in the cycle right after an item is taken with the output empty
  `HTW_ASSERT_NEXT(a_no_early_out, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer wheel testbench
// Drives add and tick words with random gaps and output stalls.
// A scoreboard class keeps its own copy of the wheel and the timer pool.
// Every result word is checked against the oldest expected word.
// ---------------------------------------------------------------------------
module tb;
  import htw_pkg::*;

  // expected result word
  typedef struct {
    logic        kind;
    logic [15:0] handle;
    logic        last;
  } wheel_result_t;

  class wheel_scoreboard;
    localparam int POOL = 64;
    localparam int SLOTS = 512;
    bit [31:0]     now_ticks;
    int            head_of[SLOTS];
    int            tail_of[SLOTS];
    bit [31:0]     expiry[POOL];
    bit [30:0]     rearm[POOL];
    bit [15:0]     tag[POOL];
    int            link[POOL];
    int            free_list;
    wheel_result_t pending_results[$];
    int            errors;

    function new();
      now_ticks = 0;
      for (int i = 0; i < SLOTS; i++) begin
        head_of[i] = POOL;
        tail_of[i] = POOL;
      end
      for (int i = 0; i < POOL; i++) link[i] = i + 1;
      free_list = 0;
      errors = 0;
    endfunction

    // choose slot from distance to expiry and append the timer
    function void place_timer(int t);
      bit [31:0] ex;
      bit [31:0] d;
      int        s;
      ex = expiry[t];
      d = ex - now_ticks;
      if (d < 32'd256) s = int'(ex[7:0]);
      else if (d < 32'd16384) s = 256 + int'(ex[13:8]);
      else if (d < 32'd1048576) s = 320 + int'(ex[19:14]);
      else if (d < 32'd67108864) s = 384 + int'(ex[25:20]);
      else if (d[31]) s = int'(now_ticks[7:0]);
      else s = 448 + int'(ex[31:26]);
      link[t] = POOL;
      if (head_of[s] == POOL) head_of[s] = t;
      else link[tail_of[s]] = t;
      tail_of[s] = t;
    endfunction

    // re-file one slot of a higher level, return index used
    function int cascade_level(int lvl);
      int        idx;
      int        s;
      int        t;
      int        nx;
      bit [31:0] sh;
      sh = now_ticks >> (8 + (lvl - 1) * 6);
      idx = int'(sh[5:0]);
      s = 256 + (lvl - 1) * 64 + idx;
      t = head_of[s];
      head_of[s] = POOL;
      tail_of[s] = POOL;
      while (t < POOL) begin
        nx = link[t];
        place_timer(t);
        t = nx;
      end
      return idx;
    endfunction

    // accepted input word: update state, queue expected results
    function void note_item(logic cmd, logic [15:0] h, logic [30:0] due, logic [30:0] per);
      wheel_result_t r;
      int            t;
      int            nx;
      int            idx;
      int            n;
      int            first;
      if (cmd == CMD_ADD) begin
        t = free_list;
        if (t >= POOL) begin
          r.kind = KIND_REJECT;
          r.handle = h;
          r.last = 1'b1;
          pending_results.push_back(r);
          return;
        end
        free_list = link[t];
        tag[t] = h;
        rearm[t] = per;
        expiry[t] = now_ticks + {1'b0, due};
        place_timer(t);
      end else begin
        idx = int'(now_ticks[7:0]);
        if (idx == 0 && cascade_level(1) == 0 && cascade_level(2) == 0 &&
            cascade_level(3) == 0)
          void'(cascade_level(4));
        t = head_of[idx];
        head_of[idx] = POOL;
        tail_of[idx] = POOL;
        n = 0;
        first = pending_results.size();
        while (t < POOL) begin
          nx = link[t];
          if (n < MAX_RESULTS) begin
            r.kind = KIND_EXPIRED;
            r.handle = tag[t];
            r.last = 1'b0;
            pending_results.push_back(r);
            n++;
          end
          if (rearm[t] != 0) begin
            expiry[t] = now_ticks + {1'b0, rearm[t]};
            place_timer(t);
          end else begin
            link[t] = free_list;
            free_list = t;
          end
          t = nx;
        end
        if (n > 0) pending_results[first + n - 1].last = 1'b1;
        now_ticks++;
      end
    endfunction

    function void check_result(logic kind, logic [15:0] h, logic last);
      wheel_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word kind=%0d handle=%h last=%0d", $time, kind, h, last);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (h !== e.handle) begin
        $display("%0t: handle expected %h actual %h", $time, e.handle, h);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // timer_handle[15:0], due_time[46:16], period[77:47]
  logic [0:0]  s_tuser = '0;   // command[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // handle_out[15:0]
  logic [0:0]  m_tuser;        // result_kind[0]
  logic        m_tlast;

  wheel_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  hierarchical_timer_wheel dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata, m_tlast);
  end

  // one input word, called at a falling edge
  task send_word(logic cmd, logic [15:0] h, logic [30:0] due, logic [30:0] per);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, per, due, h};
    do @(posedge clk); while (!s_tready);
    sb.note_item(cmd, h, due, per);
    @(negedge clk);
  endtask

  task send_random(int count, int tick_pct);
    logic [30:0] due;
    logic [30:0] per;
    int          pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        send_word(CMD_TICK, 16'($urandom), 31'($urandom), 31'($urandom));
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) due = 31'($urandom_range(300));
        else if (pick < 8) due = 31'($urandom_range(20000));
        else if (pick == 8) due = 31'($urandom);
        else due = 0;
        pick = $urandom_range(99);
        if (pick < 55) per = 0;
        else if (pick < 95) per = 31'($urandom_range(1, 300));
        else per = 31'($urandom);
        send_word(CMD_ADD, 16'($urandom), due, per);
      end
    end
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every level, due now, periodic and one-shot
    send_word(CMD_ADD, 16'h0000, 31'd0, 31'd0);
    send_word(CMD_ADD, 16'hffff, 31'h7fffffff, 31'h7fffffff);
    send_word(CMD_ADD, 16'h0101, 31'd255, 31'd0);
    send_word(CMD_ADD, 16'h0202, 31'd256, 31'd0);
    send_word(CMD_ADD, 16'h0303, 31'd16383, 31'd0);
    send_word(CMD_ADD, 16'h0404, 31'd16384, 31'd0);
    send_word(CMD_ADD, 16'h0505, 31'd1048576, 31'd0);
    send_word(CMD_ADD, 16'h0606, 31'd67108864, 31'd0);
    send_word(CMD_ADD, 16'h0707, 31'd1, 31'd2);
    send_word(CMD_ADD, 16'h0808, 31'd1, 31'd0);
    send_word(CMD_ADD, 16'h0909, 31'd0, 31'd1);
    repeat (6) send_word(CMD_TICK, 16'h0000, 31'd0, 31'd0);

    // idling phases
    send_random(60, 70);
    idle_pct = 71;
    send_random(60, 75);
    idle_pct = 0;
    stall_pct = 71;
    send_random(60, 75);

    // burst of adds against a held-off receiver: pool fills, rejects back up
    stall_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 75; i++) begin
      send_word(CMD_ADD, 16'($urandom), 31'($urandom_range(1, 60)), 31'd0);
    end

    idle_pct = 35;
    stall_pct = 35;
    send_random(60, 80);
    s_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (1000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// File: hierarchical_timer_wheel.f
+incdir+rtl/core
rtl/core/htw_pkg.sv
rtl/core/htw_ram.sv
rtl/core/htw_file.sv
rtl/core/hierarchical_timer_wheel.sv
rtl/core/htw_checker.sv
verif/tb.sv
